// ===== hw/rtl/serial_acia_register_model_top_assert.svh =====
// Assertion macros for the serial ACIA register model.
// Included by the top level; no other dependencies.
`ifndef SERIAL_ACIA_REGISTER_MODEL_TOP_ASSERT_SVH
`define SERIAL_ACIA_REGISTER_MODEL_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SACIA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("sacia assertion failed");
`define SACIA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sacia assertion failed");
`else
`define SACIA_ASSERT(lbl, clk, rstn, prop)
`define SACIA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== hw/rtl/sacia_pkg.sv =====
// Shared types and constants for the serial ACIA register model.
// No dependencies.
`default_nettype none
package sacia_pkg;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ADDR_DATA    = 2'd0,
    ADDR_STATUS  = 2'd1,
    ADDR_COMMAND = 2'd2
  } addr_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic commit;
  } ctl_t;

  // Status register bits.
  localparam int unsigned StIrqBit  = 7;
  localparam int unsigned StTdreBit = 4;
  localparam int unsigned StRdrfBit = 3;
  // Command register bit: receive interrupt disable.
  localparam int unsigned CmdIrdBit = 1;

endpackage
`default_nettype wire

// ===== hw/rtl/sacia_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sacia_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sacia_ctrl.sv =====
// Controller state machine: accepts a word, waits in S_EXEC for the queue
// read, then commits once the output register is free. Uses sacia_pkg.
`default_nettype none
module sacia_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        out_ready_i,
  output logic             out_valid_o,
  output sacia_pkg::ctl_t  ctl_o
);

  sacia_pkg::state_e state_q, state_d;
  logic              out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sacia_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    ctl_o.capture  = 1'b0;
    ctl_o.commit   = 1'b0;
    case (state_q)
      sacia_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        ctl_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = sacia_pkg::S_EXEC;
        end
      end
      sacia_pkg::S_EXEC: begin
        // The result may only land once the previous word has left.
        if (!out_valid_q || out_ready_i) begin
          ctl_o.commit = 1'b1;
          state_d      = sacia_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = sacia_pkg::S_IDLE;
      end
    endcase

    if (ctl_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== hw/rtl/sacia_dpath.sv =====
// Datapath: item registers, ACIA registers, both byte queues and the
// output register. Uses sacia_pkg and sacia_ram.
`default_nettype none
module sacia_dpath #(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  sacia_pkg::ctl_t      ctl_i,
  input  wire logic [1:0]      command_i,
  input  wire logic [1:0]      address_i,
  input  wire logic [7:0]      write_data_i,
  input  wire logic            rx_valid_i,
  input  wire logic [7:0]      rx_byte_i,
  output logic      [7:0]      read_data_o,
  output logic                 tx_valid_o,
  output logic      [7:0]      tx_byte_o,
  output logic                 irq_o
);

  localparam int unsigned PtrW = $clog2(FIFO_DEPTH);
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);
  localparam logic [PtrW:0]   DepthW  = (PtrW + 1)'(FIFO_DEPTH);
  localparam logic [CntW-1:0] CntFull = CntW'(FIFO_DEPTH);

  // Captured item.
  logic [1:0] cmd_q, addr_q;
  logic [7:0] wdata_q, rxb_q;
  logic       rxv_q;

  logic [7:0]      status_q, status_d;
  logic [7:0]      command_q, command_d;
  logic [PtrW-1:0] rx_rd_q, rx_rd_d, tx_rd_q, tx_rd_d;
  logic [CntW-1:0] rx_cnt_q, rx_cnt_d, tx_cnt_q, tx_cnt_d;

  logic [7:0] rdata, txb;
  logic       txv;

  logic            rx_push, tx_push;
  logic [PtrW:0]   rx_wsum, tx_wsum, rx_rinc, tx_rinc;
  logic [PtrW-1:0] rx_waddr, tx_waddr;
  logic [7:0]      rx_rdata, tx_rdata;

  sacia_ram #(.Width(8), .Depth(FIFO_DEPTH)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_push),
    .waddr_i (rx_waddr),
    .wdata_i (rxb_q),
    .raddr_i (rx_rd_q),
    .rdata_o (rx_rdata)
  );

  sacia_ram #(.Width(8), .Depth(FIFO_DEPTH)) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_push),
    .waddr_i (tx_waddr),
    .wdata_i (wdata_q),
    .raddr_i (tx_rd_q),
    .rdata_o (tx_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q   <= command_i;
      addr_q  <= address_i;
      wdata_q <= write_data_i;
      rxv_q   <= rx_valid_i;
      rxb_q   <= rx_byte_i;
    end
    if (ctl_i.commit) begin
      read_data_o <= rdata;
      tx_valid_o  <= txv;
      tx_byte_o   <= txb;
      irq_o       <= status_d[sacia_pkg::StIrqBit];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q  <= '0;
      command_q <= '0;
      rx_rd_q   <= '0;
      rx_cnt_q  <= '0;
      tx_rd_q   <= '0;
      tx_cnt_q  <= '0;
    end else if (ctl_i.commit) begin
      status_q  <= status_d;
      command_q <= command_d;
      rx_rd_q   <= rx_rd_d;
      rx_cnt_q  <= rx_cnt_d;
      tx_rd_q   <= tx_rd_d;
      tx_cnt_q  <= tx_cnt_d;
    end
  end

  // Write slot is the read pointer plus the fill count, wrapped once.
  always_comb begin
    rx_wsum  = (PtrW + 1)'(rx_rd_q) + (PtrW + 1)'(rx_cnt_q);
    tx_wsum  = (PtrW + 1)'(tx_rd_q) + (PtrW + 1)'(tx_cnt_q);
    rx_waddr = (rx_wsum >= DepthW) ? PtrW'(rx_wsum - DepthW) : PtrW'(rx_wsum);
    tx_waddr = (tx_wsum >= DepthW) ? PtrW'(tx_wsum - DepthW) : PtrW'(tx_wsum);
    rx_rinc  = (PtrW + 1)'(rx_rd_q) + (PtrW + 1)'(1);
    tx_rinc  = (PtrW + 1)'(tx_rd_q) + (PtrW + 1)'(1);
  end

  always_comb begin
    status_d  = status_q;
    command_d = command_q;
    rx_rd_d   = rx_rd_q;
    rx_cnt_d  = rx_cnt_q;
    tx_rd_d   = tx_rd_q;
    tx_cnt_d  = tx_cnt_q;
    rdata     = 8'h00;
    txv       = 1'b0;
    txb       = 8'h00;
    rx_push   = 1'b0;
    tx_push   = 1'b0;

    case (sacia_pkg::cmd_e'(cmd_q))
      sacia_pkg::CMD_READ: begin
        case (sacia_pkg::addr_e'(addr_q))
          sacia_pkg::ADDR_DATA: begin
            if (rx_cnt_q != '0) begin
              rdata    = rx_rdata;
              rx_rd_d  = (rx_rinc == DepthW) ? '0 : PtrW'(rx_rinc);
              rx_cnt_d = rx_cnt_q - CntW'(1);
            end
            status_d[sacia_pkg::StIrqBit] = 1'b0;
          end
          sacia_pkg::ADDR_STATUS:  rdata = status_q;
          sacia_pkg::ADDR_COMMAND: rdata = command_q;
          default: ;
        endcase
      end
      sacia_pkg::CMD_WRITE: begin
        case (sacia_pkg::addr_e'(addr_q))
          sacia_pkg::ADDR_DATA: begin
            if (tx_cnt_q != CntFull) begin
              tx_push  = 1'b1;
              tx_cnt_d = tx_cnt_q + CntW'(1);
            end
          end
          sacia_pkg::ADDR_STATUS:  status_d  = wdata_q;
          sacia_pkg::ADDR_COMMAND: command_d = wdata_q;
          default: ;
        endcase
      end
      sacia_pkg::CMD_TICK: begin
        if (rxv_q && (rx_cnt_q != CntFull)) begin
          rx_push  = 1'b1;
          rx_cnt_d = rx_cnt_q + CntW'(1);
        end
        if (tx_cnt_q != '0) begin
          txv      = 1'b1;
          txb      = tx_rdata;
          tx_rd_d  = (tx_rinc == DepthW) ? '0 : PtrW'(tx_rinc);
          tx_cnt_d = tx_cnt_q - CntW'(1);
        end
        status_d[sacia_pkg::StRdrfBit] = (rx_cnt_d != '0);
        status_d[sacia_pkg::StTdreBit] = (tx_cnt_d == '0);
        if (!command_q[sacia_pkg::CmdIrdBit] && status_d[sacia_pkg::StRdrfBit]) begin
          status_d[sacia_pkg::StIrqBit] = 1'b1;
        end
      end
      default: ;
    endcase

    // Only a committing item may touch the queues.
    rx_push = rx_push & ctl_i.commit;
    tx_push = tx_push & ctl_i.commit;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/serial_acia_register_model_top.sv =====
// Channel     | Handshake                | Word
// ------------+--------------------------+----------------------------------------------
// input       | in_valid_i / in_ready_o  | command, address, write_data, rx_valid, rx_byte
// output      | out_valid_o / out_ready_i| read_data, tx_valid, tx_byte, irq
//
// An accepted word is captured, then held in the execute state for the registered
// read of the queue memories before its register and queue updates commit into the
// output register. No new word is accepted until the last one has committed.
// Reset clears pointers, counts, status and command; queue contents need no
// clearing. A word waiting in the output register does not block acceptance;
// the following commit waits until that word is taken.
// Depends on sacia_pkg, sacia_ctrl, sacia_dpath, sacia_ram and the assert header.
`default_nettype none
`include "serial_acia_register_model_top_assert.svh"
module serial_acia_register_model_top #(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] command_i,
  input  wire logic [1:0] address_i,
  input  wire logic [7:0] write_data_i,
  input  wire logic       rx_valid_i,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic      [7:0] read_data_o,
  output logic            tx_valid_o,
  output logic      [7:0] tx_byte_o,
  output logic            irq_o
);

  sacia_pkg::ctl_t ctl;

  sacia_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .ctl_o       (ctl)
  );

  sacia_dpath #(.FIFO_DEPTH(FIFO_DEPTH)) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .command_i    (command_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .rx_valid_i   (rx_valid_i),
    .rx_byte_i    (rx_byte_i),
    .read_data_o  (read_data_o),
    .tx_valid_o   (tx_valid_o),
    .tx_byte_o    (tx_byte_o),
    .irq_o        (irq_o)
  );

  // In the cycle after a word is accepted, no other word is taken.
  `SACIA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // A commit always leaves a word in the output register.
  `SACIA_ASSERT_NEXT(a_commit_fills_out, clk_i, rst_ni, ctl.commit, out_valid_o)
  // A stalled output word is never overwritten.
  `SACIA_ASSERT(a_no_overwrite, clk_i, rst_ni, !(out_valid_o && !out_ready_i && ctl.commit))

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the serial ACIA register model.
// Holds its own predictor of the register and queue behavior; needs sacia_pkg and
// serial_acia_register_model_top.
`timescale 1ns / 1ps
module tb;

  localparam int unsigned ACIA_DEPTH   = 64;
  localparam int unsigned RANDOM_WORDS = 1100;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // Codes that the package enums leave out.
  localparam logic [1:0] CMD_NOP    = 2'd3;
  localparam logic [1:0] ADDR_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic [1:0] address;
    logic [7:0] write_data;
    logic       rx_valid;
    logic [7:0] rx_byte;
  } bus_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       irq;
  } acia_result_t;

  typedef struct packed {
    bus_word_t    word;
    logic         typed;
    acia_result_t result;
  } script_row_t;

  typedef enum int {
    MODE_FILL,
    MODE_MIX,
    MODE_DRAIN
  } traffic_e;

  logic       clk_i;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       in_ready_o;
  logic [1:0] command_i    = 2'd0;
  logic [1:0] address_i    = 2'd0;
  logic [7:0] write_data_i = 8'd0;
  logic       rx_valid_i   = 1'b0;
  logic [7:0] rx_byte_i    = 8'd0;
  logic       out_valid_o;
  logic       out_ready_i  = 1'b0;
  logic [7:0] read_data_o;
  logic       tx_valid_o;
  logic [7:0] tx_byte_o;
  logic       irq_o;

  serial_acia_register_model_top #(
    .FIFO_DEPTH(ACIA_DEPTH)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .address_i   (address_i),
    .write_data_i(write_data_i),
    .rx_valid_i  (rx_valid_i),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .read_data_o (read_data_o),
    .tx_valid_o  (tx_valid_o),
    .tx_byte_o   (tx_byte_o),
    .irq_o       (irq_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Predicted state of the block.
  logic [7:0]   rx_fifo[$];
  logic [7:0]   tx_fifo[$];
  logic [7:0]   status_q = 8'h00;
  logic [7:0]   ctrl_q   = 8'h00;

  acia_result_t pending_results[$];
  script_row_t  script[$];
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count    = 0;
  int unsigned  burst_left     = 0;
  int unsigned  pattern_age    = 0;
  logic [15:0]  stall_pattern  = '1;

  function automatic acia_result_t acia_predict(input bus_word_t w);
    acia_result_t r;
    r = '0;
    case (w.command)
      sacia_pkg::CMD_READ: begin
        case (w.address)
          sacia_pkg::ADDR_DATA: begin
            if (rx_fifo.size() != 0) r.read_data = rx_fifo.pop_front();
            status_q[sacia_pkg::StIrqBit] = 1'b0;
          end
          sacia_pkg::ADDR_STATUS:  r.read_data = status_q;
          sacia_pkg::ADDR_COMMAND: r.read_data = ctrl_q;
          default: ;
        endcase
      end
      sacia_pkg::CMD_WRITE: begin
        case (w.address)
          sacia_pkg::ADDR_DATA: begin
            if (tx_fifo.size() < ACIA_DEPTH) tx_fifo.push_back(w.write_data);
          end
          sacia_pkg::ADDR_STATUS:  status_q = w.write_data;
          sacia_pkg::ADDR_COMMAND: ctrl_q = w.write_data;
          default: ;
        endcase
      end
      sacia_pkg::CMD_TICK: begin
        if (w.rx_valid && rx_fifo.size() < ACIA_DEPTH) rx_fifo.push_back(w.rx_byte);
        if (tx_fifo.size() != 0) begin
          r.tx_valid = 1'b1;
          r.tx_byte  = tx_fifo.pop_front();
        end
        status_q[sacia_pkg::StRdrfBit] = (rx_fifo.size() != 0);
        status_q[sacia_pkg::StTdreBit] = (tx_fifo.size() == 0);
        if (!ctrl_q[sacia_pkg::CmdIrdBit] && status_q[sacia_pkg::StRdrfBit]) begin
          status_q[sacia_pkg::StIrqBit] = 1'b1;
        end
      end
      default: ;
    endcase
    r.irq = status_q[sacia_pkg::StIrqBit];
    return r;
  endfunction

  task automatic add_row(input logic [1:0] cmd, input logic [1:0] addr,
                         input logic [7:0] wdata, input logic rxv, input logic [7:0] rxb,
                         input logic typed, input logic [7:0] rdata, input logic txv,
                         input logic [7:0] txb, input logic irq);
    script_row_t row;
    row.word   = '{command: cmd, address: addr, write_data: wdata,
                   rx_valid: rxv, rx_byte: rxb};
    row.typed  = typed;
    row.result = '{read_data: rdata, tx_valid: txv, tx_byte: txb, irq: irq};
    script.push_back(row);
  endtask

  // Presents one word and holds it until the block takes it.
  task automatic send_word(input bus_word_t w, input logic typed, input acia_result_t fixed);
    acia_result_t pred;
    in_valid_i   <= 1'b1;
    command_i    <= w.command;
    address_i    <= w.address;
    write_data_i <= w.write_data;
    rx_valid_i   <= w.rx_valid;
    rx_byte_i    <= w.rx_byte;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pred = acia_predict(w);
    pending_results.push_back(typed ? fixed : pred);
  endtask

  // Bursts of back-to-back words separated by random gaps, some of them empty.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic bus_word_t make_word(input traffic_e mode);
    bus_word_t   w;
    int unsigned pick;
    w.command    = 2'($urandom_range(0, 3));
    w.address    = 2'($urandom_range(0, 3));
    w.write_data = 8'($urandom_range(0, 255));
    w.rx_valid   = 1'($urandom_range(0, 1));
    w.rx_byte    = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    case (mode)
      // Push both queues toward full so that dropped bytes show up.
      MODE_FILL: begin
        if (pick < 65) begin
          w.command = sacia_pkg::CMD_WRITE;
          w.address = sacia_pkg::ADDR_DATA;
        end else if (pick < 95) begin
          w.command  = sacia_pkg::CMD_TICK;
          w.rx_valid = 1'b1;
        end
      end
      MODE_DRAIN: begin
        if (pick < 45) begin
          w.command = sacia_pkg::CMD_READ;
          w.address = sacia_pkg::ADDR_DATA;
        end else if (pick < 80) begin
          w.command  = sacia_pkg::CMD_TICK;
          w.rx_valid = 1'b0;
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    traffic_e    mode;
    bus_word_t   w;
    int unsigned sent;
    int unsigned phase_len;
    int unsigned phase_index;

    add_row(sacia_pkg::CMD_READ,  sacia_pkg::ADDR_STATUS,  8'h00, 1'b0, 8'h00,
            1'b1, 8'h00, 1'b0, 8'h00, 1'b0);
    add_row(sacia_pkg::CMD_READ,  sacia_pkg::ADDR_COMMAND, 8'h00, 1'b0, 8'h00,
            1'b1, 8'h00, 1'b0, 8'h00, 1'b0);
    add_row(sacia_pkg::CMD_READ,  sacia_pkg::ADDR_DATA,    8'h00, 1'b0, 8'h00,
            1'b1, 8'h00, 1'b0, 8'h00, 1'b0);
    add_row(sacia_pkg::CMD_READ,  ADDR_SPARE,              8'hFF, 1'b1, 8'hFF,
            1'b1, 8'h00, 1'b0, 8'h00, 1'b0);
    add_row(CMD_NOP,              ADDR_SPARE,              8'hFF, 1'b1, 8'hFF,
            1'b1, 8'h00, 1'b0, 8'h00, 1'b0);
    add_row(sacia_pkg::CMD_TICK,  sacia_pkg::ADDR_DATA,    8'h00, 1'b0, 8'h00,
            1'b1, 8'h00, 1'b0, 8'h00, 1'b0);
    add_row(sacia_pkg::CMD_READ,  sacia_pkg::ADDR_STATUS,  8'h00, 1'b0, 8'h00,
            1'b1, 8'h10, 1'b0, 8'h00, 1'b0);
    add_row(sacia_pkg::CMD_WRITE, sacia_pkg::ADDR_COMMAND, 8'hFF, 1'b0, 8'h00,
            1'b1, 8'h00, 1'b0, 8'h00, 1'b0);
    add_row(sacia_pkg::CMD_READ,  sacia_pkg::ADDR_COMMAND, 8'h00, 1'b0, 8'h00,
            1'b1, 8'hFF, 1'b0, 8'h00, 1'b0);
    add_row(sacia_pkg::CMD_WRITE, sacia_pkg::ADDR_COMMAND, 8'h00, 1'b0, 8'h00,
            1'b1, 8'h00, 1'b0, 8'h00, 1'b0);
    add_row(sacia_pkg::CMD_TICK,  sacia_pkg::ADDR_DATA,    8'h00, 1'b1, 8'hFF,
            1'b1, 8'h00, 1'b0, 8'h00, 1'b1);
    add_row(sacia_pkg::CMD_READ,  sacia_pkg::ADDR_STATUS,  8'h00, 1'b0, 8'h00,
            1'b1, 8'h98, 1'b0, 8'h00, 1'b1);
    add_row(sacia_pkg::CMD_READ,  sacia_pkg::ADDR_DATA,    8'h00, 1'b0, 8'h00,
            1'b1, 8'hFF, 1'b0, 8'h00, 1'b0);
    add_row(sacia_pkg::CMD_WRITE, sacia_pkg::ADDR_DATA,    8'h00, 1'b0, 8'h00,
            1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
    add_row(sacia_pkg::CMD_WRITE, sacia_pkg::ADDR_DATA,    8'hFF, 1'b0, 8'h00,
            1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
    add_row(sacia_pkg::CMD_TICK,  sacia_pkg::ADDR_DATA,    8'h00, 1'b1, 8'h00,
            1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
    add_row(sacia_pkg::CMD_TICK,  sacia_pkg::ADDR_DATA,    8'h00, 1'b0, 8'h00,
            1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
    add_row(sacia_pkg::CMD_WRITE, sacia_pkg::ADDR_STATUS,  8'hFF, 1'b0, 8'h00,
            1'b1, 8'h00, 1'b0, 8'h00, 1'b1);
    add_row(sacia_pkg::CMD_WRITE, ADDR_SPARE,              8'hA5, 1'b0, 8'h00,
            1'b1, 8'h00, 1'b0, 8'h00, 1'b1);
    add_row(sacia_pkg::CMD_READ,  sacia_pkg::ADDR_DATA,    8'h00, 1'b0, 8'h00,
            1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
    add_row(sacia_pkg::CMD_WRITE, sacia_pkg::ADDR_STATUS,  8'h00, 1'b0, 8'h00,
            1'b1, 8'h00, 1'b0, 8'h00, 1'b0);
    add_row(sacia_pkg::CMD_WRITE, sacia_pkg::ADDR_COMMAND, 8'h02, 1'b0, 8'h00,
            1'b1, 8'h00, 1'b0, 8'h00, 1'b0);
    // Receive interrupt disabled: data arrives but irq stays low.
    add_row(sacia_pkg::CMD_TICK,  sacia_pkg::ADDR_DATA,    8'h00, 1'b1, 8'h5A,
            1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
    add_row(sacia_pkg::CMD_READ,  sacia_pkg::ADDR_STATUS,  8'h00, 1'b0, 8'h00,
            1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
    add_row(sacia_pkg::CMD_WRITE, sacia_pkg::ADDR_COMMAND, 8'h00, 1'b0, 8'h00,
            1'b1, 8'h00, 1'b0, 8'h00, 1'b0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      send_word(script[i].word, script[i].typed, script[i].result);
      pace_sender();
    end
    wait_until_drained();

    sent = 0;
    phase_index = 0;
    while (sent < RANDOM_WORDS) begin
      mode = traffic_e'(phase_index % 3);
      phase_len = (mode == MODE_FILL) ? $urandom_range(200, 320) : $urandom_range(120, 260);
      for (int unsigned k = 0; k < phase_len && sent < RANDOM_WORDS; k++) begin
        w = make_word(mode);
        send_word(w, 1'b0, '0);
        sent++;
        pace_sender();
      end
      // Let the block run dry between traffic phases.
      wait_until_drained();
      phase_index++;
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Receiver stalls follow a rotating pattern that is replaced now and then;
  // every pattern has at least two ready cycles in sixteen.
  always @(posedge clk_i) begin
    if (pattern_age == 0) begin
      pattern_age   = $urandom_range(16, 96);
      stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                  : (16'($urandom) | 16'h0101);
    end
    pattern_age--;
    stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
    out_ready_i <= stall_pattern[0];
  end

  task automatic check_field(input string label, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %02h, actual %02h", $time, label, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    acia_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: word out with none expected, actual %02h %0b %02h %0b",
                 $time, read_data_o, tx_valid_o, tx_byte_o, irq_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("read_data", want.read_data, read_data_o);
        check_field("tx_valid", {7'd0, want.tx_valid}, {7'd0, tx_valid_o});
        check_field("tx_byte", want.tx_byte, tx_byte_o);
        check_field("irq", {7'd0, want.irq}, {7'd0, irq_o});
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d words outstanding", $time, pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

endmodule
